[hdl/fpa_pkg.sv]
// shared types, operation codes and helpers for the fixed point alu
`default_nettype none
package fpa_pkg;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_MIN      = 4'd4;
    localparam logic [3:0] OP_MAX      = 4'd5;
    localparam logic [3:0] OP_INC      = 4'd6;
    localparam logic [3:0] OP_DEC      = 4'd7;
    localparam logic [3:0] OP_TO_INT   = 4'd8;
    localparam logic [3:0] OP_FROM_INT = 4'd9;

    localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // per item control carried down the pipeline
    typedef struct packed {
        logic [3:0]  op;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        neg;
        logic        dz;
        logic [31:0] simple;
        logic        simple_ovf;
        logic [63:0] prod;
        logic [31:0] rem;
        logic [31:0] dvs;
    } ctl_t;

    // saturated signed value from sign and magnitude, overflow in the top bit
    function automatic logic [32:0] from_mag(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (neg) begin
            if (mag > {32'd0, SAT_NEG}) r = {1'b1, SAT_NEG};
            else r = {1'b0, 32'd0 - mag[31:0]};
        end else begin
            if (mag > {32'd0, SAT_POS}) r = {1'b1, SAT_POS};
            else r = {1'b0, mag[31:0]};
        end
        return r;
    endfunction

    // saturate a 33-bit signed sum
    function automatic logic [32:0] clamp33(input logic [32:0] s);
        logic [32:0] r;
        if (s[32] != s[31]) r = {1'b1, (s[32] ? SAT_NEG : SAT_POS)};
        else r = {1'b0, s[31:0]};
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/fixed_point_alu_top.sv]
// top level of the q24.8 fixed point alu
//
//  channel  | direction | handshake          | payload
//  s_       | in        | s_valid / s_ready  | operation, operand_a, operand_b
//  m_       | out       | m_valid / m_ready  | result_value, compare, divide and overflow flags
//
// one item per cycle while results are taken; the path is the front stage, one
// divider cell per dividend bit and the output register.
// the divider cell chain sets the latency; the 32x32 product in the front stage
// sets the cycle time.
// aresetn clears only the stage valid bits.
// each stage moves when the stage after it is empty or moving, so a stalled
// result lets earlier stages keep filling.
`default_nettype none
module fixed_point_alu_top #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [3:0]         s_operation,
    input  wire logic signed [31:0] s_operand_a,
    input  wire logic signed [31:0] s_operand_b,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_result_value,
    output logic                    m_is_less,
    output logic                    m_is_equal,
    output logic                    m_is_greater,
    output logic                    m_divide_by_zero,
    output logic                    m_overflowed
);
    import fpa_pkg::*;

    localparam int NW = 32 + FRAC_BITS;

    logic           cv [0:NW];
    logic           cr [0:NW];
    ctl_t           cc [0:NW];
    logic [NW-1:0]  cn [0:NW];

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_op(s_operation), .in_a(s_operand_a), .in_b(s_operand_b),
        .out_valid(cv[0]), .out_ready(cr[0]), .out_ctl(cc[0]), .out_nq(cn[0])
    );

    // divider cell chain
    for (genvar i = 0; i < NW; i++) begin : g_cell
        fpa_div_cell #(.NW(NW)) u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .in_valid(cv[i]), .in_ready(cr[i]), .in_ctl(cc[i]), .in_nq(cn[i]),
            .out_valid(cv[i+1]), .out_ready(cr[i+1]), .out_ctl(cc[i+1]),
            .out_nq(cn[i+1])
        );
    end

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(cv[NW]), .in_ready(cr[NW]), .in_ctl(cc[NW]), .in_nq(cn[NW]),
        .out_valid(m_valid), .out_ready(m_ready),
        .out_value(m_result_value), .out_lt(m_is_less), .out_eq(m_is_equal),
        .out_gt(m_is_greater), .out_dz(m_divide_by_zero), .out_ovf(m_overflowed)
    );

endmodule
`default_nettype wire

[hdl/fpa_front.sv]
// input stage: decode, compare, simple results, magnitude product, divider setup
`default_nettype none
module fpa_front #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [3:0]               in_op,
    input  wire logic signed [31:0]       in_a,
    input  wire logic signed [31:0]       in_b,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output fpa_pkg::ctl_t                 out_ctl,
    output logic [32+FRAC_BITS-1:0]       out_nq
);
    import fpa_pkg::*;

    logic                     v_reg;
    ctl_t                     ctl_reg, ctl_next;
    logic [32+FRAC_BITS-1:0]  nq_reg, nq_next;

    logic [31:0] mag_a, mag_b, ti;
    logic [63:0] fi;
    logic [32:0] r33;

    assign in_ready = !v_reg || out_ready;

    // magnitudes and the simple results
    always_comb begin
        mag_a = in_a[31] ? 32'd0 - in_a : in_a;
        mag_b = in_b[31] ? 32'd0 - in_b : in_b;
        fi    = {32'd0, mag_a} << FRAC_BITS;
        ti    = mag_a >> FRAC_BITS;
        r33   = 33'd0;
        unique case (in_op)
            OP_ADD:      r33 = clamp33({in_a[31], in_a} + {in_b[31], in_b});
            OP_SUB:      r33 = clamp33({in_a[31], in_a} - {in_b[31], in_b});
            OP_INC:      r33 = clamp33({in_a[31], in_a} + 33'd1);
            OP_DEC:      r33 = clamp33({in_a[31], in_a} - 33'd1);
            OP_MIN:      r33 = {1'b0, (in_a < in_b) ? in_a : in_b};
            OP_MAX:      r33 = {1'b0, (in_a > in_b) ? in_a : in_b};
            OP_TO_INT:   r33 = {1'b0, in_a[31] ? 32'd0 - ti : ti};
            OP_FROM_INT: r33 = from_mag(in_a[31], fi);
            default:     r33 = 33'd0;
        endcase
        ctl_next.op         = in_op;
        ctl_next.lt         = in_a < in_b;
        ctl_next.eq         = in_a == in_b;
        ctl_next.gt         = in_a > in_b;
        ctl_next.neg        = in_a[31] ^ in_b[31];
        ctl_next.dz         = (in_op == OP_DIV) && (in_b == 32'sd0);
        ctl_next.simple     = r33[31:0];
        ctl_next.simple_ovf = r33[32];
        ctl_next.prod       = {32'd0, mag_a} * {32'd0, mag_b};
        ctl_next.rem        = 32'd0;
        ctl_next.dvs        = mag_b;
        nq_next             = {mag_a, {FRAC_BITS{1'b0}}};
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= 1'b0;
        else if (in_ready) v_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg <= ctl_next;
            nq_reg  <= nq_next;
        end
    end

    assign out_valid = v_reg;
    assign out_ctl   = ctl_reg;
    assign out_nq    = nq_reg;

endmodule
`default_nettype wire

[hdl/fpa_div_cell.sv]
// one restoring division step, one quotient bit per cell
`default_nettype none
module fpa_div_cell #(
    parameter int NW = 40
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire fpa_pkg::ctl_t  in_ctl,
    input  wire logic [NW-1:0]  in_nq,
    output logic                out_valid,
    input  wire logic           out_ready,
    output fpa_pkg::ctl_t       out_ctl,
    output logic [NW-1:0]       out_nq
);
    import fpa_pkg::*;

    logic           v_reg;
    ctl_t           ctl_reg, ctl_next;
    logic [NW-1:0]  nq_reg, nq_next;
    logic [32:0]    shifted, diff;
    logic           ge;

    assign in_ready = !v_reg || out_ready;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        shifted  = {in_ctl.rem, in_nq[NW-1]};
        diff     = shifted - {1'b0, in_ctl.dvs};
        ge       = shifted >= {1'b0, in_ctl.dvs};
        ctl_next = in_ctl;
        ctl_next.rem = ge ? diff[31:0] : shifted[31:0];
        nq_next  = {in_nq[NW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= 1'b0;
        else if (in_ready) v_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg <= ctl_next;
            nq_reg  <= nq_next;
        end
    end

    assign out_valid = v_reg;
    assign out_ctl   = ctl_reg;
    assign out_nq    = nq_reg;

endmodule
`default_nettype wire

[hdl/fpa_back.sv]
// output stage: rounding and saturation of multiply and divide, result register
`default_nettype none
module fpa_back #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire fpa_pkg::ctl_t            in_ctl,
    input  wire logic [32+FRAC_BITS-1:0]  in_nq,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [31:0]            out_value,
    output logic                          out_lt,
    output logic                          out_eq,
    output logic                          out_gt,
    output logic                          out_dz,
    output logic                          out_ovf
);
    import fpa_pkg::*;

    logic        v_reg;
    logic [31:0] value_reg, value_next;
    logic        lt_reg, eq_reg, gt_reg, dz_reg, ovf_reg, ovf_next;
    logic [63:0] pr, qm, qd;
    logic        rnd;
    logic [32:0] r33;

    assign in_ready = !v_reg || out_ready;

    // final result selection
    always_comb begin
        pr  = in_ctl.prod + (64'd1 << (FRAC_BITS - 1));
        qm  = pr >> FRAC_BITS;
        rnd = {in_ctl.rem, 1'b0} >= {1'b0, in_ctl.dvs};
        qd  = 64'(in_nq) + {63'd0, rnd};
        unique case (in_ctl.op)
            OP_MUL:  r33 = from_mag(in_ctl.neg, qm);
            OP_DIV:  r33 = in_ctl.dz ? 33'd0 : from_mag(in_ctl.neg, qd);
            default: r33 = {in_ctl.simple_ovf, in_ctl.simple};
        endcase
        value_next = r33[31:0];
        ovf_next   = r33[32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= 1'b0;
        else if (in_ready) v_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            value_reg <= value_next;
            ovf_reg   <= ovf_next;
            lt_reg    <= in_ctl.lt;
            eq_reg    <= in_ctl.eq;
            gt_reg    <= in_ctl.gt;
            dz_reg    <= in_ctl.dz;
        end
    end

    assign out_valid = v_reg;
    assign out_value = value_reg;
    assign out_lt    = lt_reg;
    assign out_eq    = eq_reg;
    assign out_gt    = gt_reg;
    assign out_dz    = dz_reg;
    assign out_ovf   = ovf_reg;

endmodule
`default_nettype wire

[hdl/fpa_checker.sv]
// port level checks for the fixed point alu and their bind
`default_nettype none
module fpa_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [3:0]         s_operation,
    input wire logic signed [31:0] s_operand_a,
    input wire logic signed [31:0] s_operand_b,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_result_value,
    input wire logic               m_is_less,
    input wire logic               m_is_equal,
    input wire logic               m_is_greater,
    input wire logic               m_divide_by_zero,
    input wire logic               m_overflowed
);
    import fpa_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value))
        else $error("stalled result changed");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // exactly one compare flag per item
    a_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_is_less, m_is_equal, m_is_greater}))
        else $error("compare flags not one hot");

    // divide by zero gives zero without overflow
    a_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_result_value == 32'sd0 && !m_overflowed)
        else $error("bad divide by zero result");

    // overflow means a saturated value
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflowed |->
            m_result_value == SAT_POS || m_result_value == SAT_NEG)
        else $error("overflow without saturation");

endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (.*);
`default_nettype wire
